@@ hdl/adaa_pkg.sv @@
package adaa_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_WR_F    = 2'd1,
    OP_WR_AD   = 2'd2,
    OP_REFRESH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_INPUT_LIMIT     = 2'd0,
    REG_INDEX_SCALE     = 2'd1,
    REG_DELTA_THRESHOLD = 2'd2,
    REG_NONE            = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_MUL,
    S_RDA,
    S_RDB,
    S_SUB,
    S_IMUL,
    S_ADD,
    S_FDONE,
    S_SEL,
    S_DIV,
    S_QEND,
    S_SHDONE,
    S_MIX1,
    S_MIX2,
    S_MIX3,
    S_DONE
  } state_t;

  localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S24_MIN = -24'sh800000;
  localparam logic [22:0] LIMIT_RESET = 23'd3145728;
  localparam logic [23:0] SCALE_RESET = 24'd2796203;
  localparam logic [15:0] THRESH_RESET = 16'd0;
  localparam logic [16:0] LEVEL_ONE = 17'd65536;
  localparam int DIV_STEPS = 23;

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'(S24_MAX)) return S24_MAX;
    if (v < 48'(S24_MIN)) return S24_MIN;
    return v[23:0];
  endfunction

endpackage

@@ hdl/adaa_table_waveshaper_top.sv @@
// channel   handshake              payload
// in        in_valid / in_ready    operation channel sample mix_level entry_index entry_value
// cfg       cfg_valid / cfg_ready  cfg_index cfg_data
// out       out_valid / out_ready  out_channel out_sample
//
// table writes are taken back to back; a level 0 sample skips the work and is passed on unchanged
// a sample is worked with the 23 step divider, or through the F table when the step is small;
// in either case the AD table read is skipped when the sample is beyond the table range
// a refresh also skips the table read beyond the table range; one request at a time
// the output register holds a result while the next request is worked; a full output stalls
// rst clears the channel history, config registers, state and out_valid; the tables are not cleared
module adaa_table_waveshaper_top
  import adaa_pkg::*;
#(
  parameter int TABLE_DEPTH   = 2048,
  parameter int CHANNEL_COUNT = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [0:0]         channel,
  input  logic signed [23:0] sample,
  input  logic [16:0]        mix_level,
  input  logic [10:0]        entry_index,
  input  logic signed [23:0] entry_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [0:0]         out_channel,
  output logic signed [23:0] out_sample
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  state_t state, state_next;

  logic [22:0] input_limit;
  logic [23:0] index_scale;
  logic [15:0] delta_threshold;

  logic signed [23:0] sh_mem [TABLE_DEPTH];
  logic signed [23:0] ad_mem [TABLE_DEPTH];
  logic signed [23:0] sh_q, ad_q, tq;
  logic [AW-1:0] raddr, a_idx;

  logic signed [23:0] last_s  [CHANNEL_COUNT];
  logic signed [23:0] last_ad [CHANNEL_COUNT];

  logic accept, is_refresh, tsel, clamp;
  logic [CH_W-1:0] ch;
  logic signed [23:0] x;
  logic [16:0] level;
  logic [23:0] mag_x;
  logic [47:0] pos;
  logic signed [23:0] a_reg;
  logic signed [24:0] diff;
  logic signed [45:0] prod;
  logic signed [25:0] lk;
  logic signed [23:0] fx, wet, res;
  logic signed [24:0] delta;
  logic [24:0] mag_d, dmag;
  logic signed [24:0] dfs;
  logic [24:0] rem;
  logic [25:0] rem_sh;
  logic [22:0] nb, quo;
  logic [4:0] cnt;
  logic neg, ovf;
  logic signed [41:0] p1, p2;
  logic [16:0] lvl_in;
  logic ch_ok;
  logic [16:0] idx_hi;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign ch_ok     = 32'(channel) < CHANNEL_COUNT;
  assign lvl_in    = (mix_level > LEVEL_ONE) ? LEVEL_ONE : mix_level;
  assign mag_x     = x[23] ? 24'(-25'(x)) : 24'(x);
  assign tq        = tsel ? sh_q : ad_q;
  assign idx_hi    = {1'b0, pos[47:32]};
  assign mag_d     = delta[24] ? 25'(-delta) : 25'(delta);
  assign dfs       = 25'(fx) - 25'(last_ad[ch]);
  assign rem_sh    = {rem, nb[22]};

  always_ff @(posedge clk) begin
    if (rst) begin
      input_limit     <= LIMIT_RESET;
      index_scale     <= SCALE_RESET;
      delta_threshold <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_INPUT_LIMIT:     input_limit     <= cfg_data[22:0];
        REG_INDEX_SCALE:     index_scale     <= cfg_data;
        REG_DELTA_THRESHOLD: delta_threshold <= cfg_data[15:0];
        REG_NONE: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op_t'(operation) == OP_WR_F && 32'(entry_index) < TABLE_DEPTH) begin
      sh_mem[AW'(entry_index)] <= entry_value;
    end
    sh_q <= sh_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && op_t'(operation) == OP_WR_AD && 32'(entry_index) < TABLE_DEPTH) begin
      ad_mem[AW'(entry_index)] <= entry_value;
    end
    ad_q <= ad_mem[raddr];
  end

  always_comb begin
    state_next = state;
    raddr      = a_idx;
    unique case (state)
      S_IDLE: begin
        if (accept && ch_ok) begin
          if (op_t'(operation) == OP_SAMPLE) begin
            state_next = (mix_level == 17'd0) ? S_DONE : S_START;
          end else if (op_t'(operation) == OP_REFRESH) begin
            state_next = S_START;
          end
        end
      end
      S_START:  state_next = ({1'b0, mag_x} > {2'b0, input_limit}) ? S_FDONE : S_RDA;
      S_MUL:    state_next = S_RDA;
      S_RDA: begin
        raddr      = (idx_hi >= 17'(TABLE_DEPTH - 1)) ? LAST_ADDR : AW'(pos[47:32]);
        state_next = S_RDB;
      end
      S_RDB: begin
        raddr      = a_idx + AW'(1);
        state_next = S_SUB;
      end
      S_SUB:    state_next = S_IMUL;
      S_IMUL:   state_next = S_ADD;
      S_ADD:    state_next = tsel ? S_SHDONE : S_FDONE;
      S_FDONE:  state_next = is_refresh ? S_IDLE : S_SEL;
      S_SEL:    state_next = (mag_d <= 25'(delta_threshold)) ? S_MUL : S_DIV;
      S_DIV:    state_next = (cnt == 5'd1) ? S_QEND : S_DIV;
      S_QEND:   state_next = S_MIX1;
      S_SHDONE: state_next = S_MIX1;
      S_MIX1:   state_next = S_MIX2;
      S_MIX2:   state_next = S_MIX3;
      S_MIX3:   state_next = S_DONE;
      S_DONE:   state_next = (!out_valid || out_ready) ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        last_s[i]  <= '0;
        last_ad[i] <= '0;
      end
    end else if (state == S_FDONE && is_refresh) begin
      last_ad[ch] <= sat24(48'(lk));
    end else if (state == S_MIX1) begin
      last_s[ch]  <= x;
      last_ad[ch] <= fx;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ch         <= CH_W'(channel);
          level      <= lvl_in;
          tsel       <= 1'b0;
          is_refresh <= (op_t'(operation) == OP_REFRESH);
          x          <= (op_t'(operation) == OP_REFRESH) ? last_s[CH_W'(channel)] : sample;
          res        <= sample;
        end
      end
      S_START: begin
        pos <= mag_x * index_scale;
        lk  <= 26'(mag_x);
      end
      S_MUL: begin
        pos  <= mag_x * index_scale;
        tsel <= 1'b1;
      end
      S_RDA: begin
        a_idx <= raddr;
        clamp <= (idx_hi >= 17'(TABLE_DEPTH - 1));
      end
      S_RDB: a_reg <= tq;
      S_SUB: diff <= 25'(tq) - 25'(a_reg);
      S_IMUL: prod <= diff * $signed({1'b0, pos[31:12]});
      S_ADD: lk <= clamp ? 26'(a_reg) : 26'(a_reg) + 26'(prod >>> 20);
      S_FDONE: begin
        fx    <= sat24(48'(lk));
        delta <= 25'(x) - 25'(last_s[ch]);
      end
      S_SEL: begin
        dmag <= mag_d;
        neg  <= dfs[24] ^ delta[24];
        ovf  <= {3'b0, (dfs[24] ? 25'(-dfs) : 25'(dfs))} >= {mag_d, 3'b0};
        rem  <= 25'((dfs[24] ? 25'(-dfs) : 25'(dfs)) >> 3);
        nb   <= {(dfs[24] ? 3'(-dfs) : 3'(dfs)), 20'b0};
        cnt  <= 5'(DIV_STEPS);
        quo  <= '0;
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, dmag}) begin
          rem <= 25'(rem_sh - {1'b0, dmag});
          quo <= {quo[21:0], 1'b1};
        end else begin
          rem <= rem_sh[24:0];
          quo <= {quo[21:0], 1'b0};
        end
        nb  <= {nb[21:0], 1'b0};
        cnt <= cnt - 5'd1;
      end
      S_QEND: begin
        if (ovf) begin
          wet <= neg ? S24_MIN : S24_MAX;
        end else begin
          wet <= neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        end
      end
      S_SHDONE: wet <= x[23] ? sat24(-48'(lk)) : sat24(48'(lk));
      S_MIX1: p1 <= $signed({1'b0, level}) * wet;
      S_MIX2: p2 <= $signed({1'b0, 17'(LEVEL_ONE - level)}) * x;
      S_MIX3: begin
        res <= sat24(48'((43'(p1) + 43'(p2) + 43'sd32768) >>> 16));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_channel <= 1'(ch);
      out_sample  <= res;
    end
  end

endmodule
